// ===== sv/weighted_majority_window_vote_assert.svh =====
// Assertion macros used by the vote block checker.
`ifndef WEIGHTED_MAJORITY_WINDOW_VOTE_ASSERT_SVH
`define WEIGHTED_MAJORITY_WINDOW_VOTE_ASSERT_SVH

// Clocked property with the active-low reset disabling the check.
`define WMWV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define WMWV_ASSERT_IMPL(lbl, ante, cons, msg) \
    `WMWV_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== sv/wmwv_pkg.sv =====
// Types and constants of the weighted majority window vote block.
package wmwv_pkg;

    typedef logic [7:0]  t_label;
    typedef logic [15:0] t_votes;
    typedef logic [7:0]  t_weight;

    localparam t_label  NODATA_LABEL        = 8'd255;
    localparam t_votes  VOTE_MAX            = 16'hFFFF;
    localparam t_weight CENTER_WEIGHT_RESET = 8'd1;
    localparam t_weight PLAIN_WEIGHT        = 8'd1;

endpackage

// ===== sv/wmwv_if.sv =====
// Handshake interfaces for pixel items, result items and configuration writes.
interface wmwv_in_if import wmwv_pkg::*; ();
    logic   valid;
    logic   ready;
    t_label pixel_label;
    logic   is_center;
    logic   window_last;

    modport source (output valid, output pixel_label, output is_center,
                    output window_last, input ready);
    modport sink   (input valid, input pixel_label, input is_center,
                    input window_last, output ready);
endinterface

interface wmwv_out_if import wmwv_pkg::*; ();
    logic   valid;
    logic   ready;
    t_label filtered_label;
    logic   nodata_hit;
    t_votes winning_votes;

    modport source (output valid, output filtered_label, output nodata_hit,
                    output winning_votes, input ready);
    modport sink   (input valid, input filtered_label, input nodata_hit,
                    input winning_votes, output ready);
endinterface

interface wmwv_cfg_if import wmwv_pkg::*; ();
    logic    valid;
    logic    ready;
    t_weight center_weight;

    modport source (output valid, output center_weight, input ready);
    modport sink   (input valid, input center_weight, output ready);
endinterface

// ===== sv/weighted_majority_window_vote.sv =====
// Weighted majority vote over a window of labels: one pixel item per cycle sustained.
// The window's last pixel item passes the vote stage register, then the result register that drives o_res.
// Throughput is set by the vote memory read-modify-write, one read and one write per cycle,
// with forwarding of the previous write; only a stalled result holds the last pixel item.
// Synchronous active-low reset clears the seen bits, running winner and handshake state;
// the vote memory needs no clearing pass since entries are only read when marked seen.
module weighted_majority_window_vote import wmwv_pkg::*; #(
    parameter int LABEL_COUNT = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wmwv_in_if.sink    i_pix,
    wmwv_out_if.source o_res,
    wmwv_cfg_if.sink   i_cfg
);

    localparam int         LW          = $clog2(LABEL_COUNT);
    localparam logic [8:0] LABEL_LIMIT = 9'(LABEL_COUNT);

    // Configuration register.
    t_weight r_center_weight;

    // Vote memory and its registered read data.
    t_votes            r_votes_mem [LABEL_COUNT];
    t_votes            r_rd_data;
    logic [LABEL_COUNT-1:0] r_seen;
    logic [LABEL_COUNT-1:0] n_seen;

    // Vote stage registers.
    logic    r_s1_valid;
    t_label  r_s1_label;
    logic    r_s1_center;
    logic    r_s1_last;

    // Last write, kept for forwarding into the next read.
    logic          r_fwd_valid;
    logic [LW-1:0] r_fwd_idx;
    t_votes        r_fwd_count;

    // Running window state.
    t_label r_best_label;
    t_votes r_best_votes;
    t_label r_center_label;
    logic   r_nodata;
    t_label n_best_label;
    t_votes n_best_votes;
    t_label n_center_label;
    logic   n_nodata;

    // Result register.
    logic   r_out_valid;
    t_label r_out_label;
    logic   r_out_nodata;
    t_votes r_out_votes;

    logic          advance;
    logic          accept;
    logic [LW-1:0] in_idx;
    logic [LW-1:0] s1_idx;
    logic          s1_vote;
    t_votes        base;
    t_weight       weight;
    logic [16:0]   sum;
    t_votes        count;
    logic          better;

    // The pipeline moves unless a finished window waits behind a stalled result.
    assign advance = !(r_s1_valid && r_s1_last && r_out_valid && !o_res.ready);
    assign accept  = i_pix.valid && advance;
    assign in_idx  = i_pix.pixel_label[LW-1:0];
    assign i_pix.ready = advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_weight <= CENTER_WEIGHT_RESET;
        end else if (i_cfg.valid) begin
            r_center_weight <= i_cfg.center_weight;
        end
    end

    // Read port: issued as the pixel item is accepted.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_votes_mem[in_idx];
        end
    end

    // Write port: the updated count of the item in the vote stage.
    always_ff @(posedge i_clk) begin
        if (advance && s1_vote) begin
            r_votes_mem[s1_idx] <= count;
        end
    end

    // Vote arithmetic with forwarding of the previous same-label write.
    always_comb begin
        s1_idx  = r_s1_label[LW-1:0];
        s1_vote = r_s1_valid && (r_s1_label != NODATA_LABEL)
                  && ({1'b0, r_s1_label} < LABEL_LIMIT);
        if (!r_seen[s1_idx]) begin
            base = '0;
        end else if (r_fwd_valid && (r_fwd_idx == s1_idx)) begin
            base = r_fwd_count;
        end else begin
            base = r_rd_data;
        end
        weight = r_s1_center ? r_center_weight : PLAIN_WEIGHT;
        sum    = {1'b0, base} + {9'd0, weight};
        count  = sum[16] ? VOTE_MAX : sum[15:0];
        better = (count > r_best_votes)
                 || ((count == r_best_votes) && (r_s1_label < r_best_label));
    end

    // Next window state including the item in the vote stage.
    always_comb begin
        n_best_label   = r_best_label;
        n_best_votes   = r_best_votes;
        n_center_label = r_s1_center ? r_s1_label : r_center_label;
        n_nodata       = r_nodata || (r_s1_label == NODATA_LABEL);
        n_seen         = r_seen;
        if (s1_vote) begin
            n_seen[s1_idx] = 1'b1;
            if (better) begin
                n_best_label = r_s1_label;
                n_best_votes = count;
            end
        end
    end

    // Stage and window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_fwd_valid    <= 1'b0;
            r_seen         <= '0;
            r_best_label   <= '0;
            r_best_votes   <= '0;
            r_center_label <= '0;
            r_nodata       <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= accept;
            r_fwd_valid <= s1_vote;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_seen         <= '0;
                    r_best_label   <= '0;
                    r_best_votes   <= '0;
                    r_center_label <= '0;
                    r_nodata       <= 1'b0;
                end else begin
                    r_seen         <= n_seen;
                    r_best_label   <= n_best_label;
                    r_best_votes   <= n_best_votes;
                    r_center_label <= n_center_label;
                    r_nodata       <= n_nodata;
                end
            end
        end
    end

    // Payload of the vote stage and forwarding register.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_label  <= i_pix.pixel_label;
            r_s1_center <= i_pix.is_center;
            r_s1_last   <= i_pix.window_last;
            r_fwd_idx   <= s1_idx;
            r_fwd_count <= count;
        end
    end

    // Result register, loaded at the end of each window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_s1_valid && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid && r_s1_last) begin
            r_out_nodata <= n_nodata;
            r_out_label  <= n_nodata ? n_center_label : n_best_label;
            r_out_votes  <= n_nodata ? '0 : n_best_votes;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.filtered_label = r_out_label;
    assign o_res.nodata_hit     = r_out_nodata;
    assign o_res.winning_votes  = r_out_votes;

endmodule

// ===== sv/wmwv_checker.sv =====
// Port-level checker for the weighted majority window vote block, with its bind.
`include "weighted_majority_window_vote_assert.svh"

module wmwv_checker import wmwv_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_in_last,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_label i_out_label,
    input logic   i_out_nodata,
    input t_votes i_out_votes
);

    // A stalled result item keeps its label and votes.
    `WMWV_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_label) && $stable(i_out_votes), "result changed while stalled")

    // A nodata window reports no votes.
    `WMWV_ASSERT_IMPL(a_nodata_votes, i_out_valid && i_out_nodata, i_out_votes == 16'd0, "nodata result with votes")

    // A window without votes falls back to label zero.
    `WMWV_ASSERT_IMPL(a_zero_votes, i_out_valid && !i_out_nodata && (i_out_votes == 16'd0), i_out_label == 8'd0, "zero-vote window not label zero")

    // A new result item rises only after a window's last pixel item has been accepted
    // and has passed through the vote stage register.
    `WMWV_ASSERT_IMPL(a_out_after_last, $rose(i_out_valid), $past(i_in_valid && i_in_ready && i_in_last, 2), "result without a last pixel item")

endmodule

bind weighted_majority_window_vote wmwv_checker u_wmwv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_in_last    (i_pix.window_last),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_label  (o_res.filtered_label),
    .i_out_nodata (o_res.nodata_hit),
    .i_out_votes  (o_res.winning_votes)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the weighted majority window vote block.
module testbench;
    import wmwv_pkg::*;

    localparam int          LABEL_COUNT  = 256;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 120;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          SAT_WINDOW   = 260;
    localparam int          DIRECTED_N   = 25;

    // One result item as the block reports it.
    typedef struct packed {
        t_label label;
        logic   nodata;
        t_votes votes;
    } t_vote_result;

    // One row of the directed stimulus; a weight change happens before the row's item.
    typedef struct packed {
        t_label  label;
        logic    center;
        logic    last;
        logic    set_weight;
        t_weight weight;
        logic    typed;
        t_label  want_label;
        logic    want_nodata;
        t_votes  want_votes;
    } t_pixel_row;

    // Directed windows: reset weight, ties, nodata cases, zero and full weights.
    localparam t_pixel_row DIRECTED [DIRECTED_N] = '{
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b1, 8'd0,   1'b0, 16'd1},
        '{8'd254, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd254, 1'b0, 1'b1, 1'b0, 8'd0,   1'b1, 8'd254, 1'b0, 16'd2},
        '{8'd7,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd3,   1'b0, 1'b1, 1'b0, 8'd0,   1'b1, 8'd3,   1'b0, 16'd1},
        '{8'd255, 1'b1, 1'b1, 1'b0, 8'd0,   1'b1, 8'd255, 1'b1, 16'd0},
        '{8'd255, 1'b0, 1'b1, 1'b0, 8'd0,   1'b1, 8'd0,   1'b1, 16'd0},
        '{8'd10,  1'b1, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd20,  1'b1, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd20,  1'b0, 1'b1, 1'b0, 8'd0,   1'b1, 8'd20,  1'b0, 16'd2},
        '{8'd10,  1'b1, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd255, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd30,  1'b1, 1'b1, 1'b0, 8'd0,   1'b1, 8'd30,  1'b1, 16'd0},
        '{8'd9,   1'b1, 1'b1, 1'b1, 8'd0,   1'b1, 8'd0,   1'b0, 16'd0},
        '{8'd9,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd200, 1'b0, 1'b1, 1'b0, 8'd0,   1'b1, 8'd200, 1'b0, 16'd1},
        '{8'd4,   1'b1, 1'b0, 1'b1, 8'd255, 1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd5,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd5,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd5,   1'b0, 1'b1, 1'b0, 8'd0,   1'b1, 8'd4,   1'b0, 16'd255},
        '{8'd128, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd127, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd128, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd85,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0},
        '{8'd170, 1'b1, 1'b1, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    wmwv_in_if  pix_if ();
    wmwv_out_if res_if ();
    wmwv_cfg_if cfg_if ();

    weighted_majority_window_vote #(
        .LABEL_COUNT(LABEL_COUNT)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_pix  (pix_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    // Free-running clock, period 12.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Vote state mirrored from the block.
    t_votes  tally_count [LABEL_COUNT];
    bit      tally_seen  [LABEL_COUNT];
    t_label  lead_label;
    t_votes  lead_votes;
    t_label  tally_center;
    bit      tally_nodata;
    t_weight weight_now;

    t_vote_result expected_results [$];

    int unsigned cycle_count;
    int          mismatches;
    int          pixel_count;
    int          window_count;
    int          nodata_windows;
    int          saturated_windows;
    int          weight_writes;
    bit          sender_gapless;
    bit          receiver_gapless;
    bit          hold_request;

    // Adds one pixel to the running tally; returns 1 with the result on a window's last pixel.
    function automatic bit tally_pixel(t_label lbl, logic ctr, logic lst,
                                       output t_vote_result res);
        logic [16:0] sum;
        res = '0;
        if (ctr)
            tally_center = lbl;
        if (lbl == NODATA_LABEL) begin
            tally_nodata = 1'b1;
        end else if (int'(lbl) < LABEL_COUNT) begin
            sum = {9'd0, (ctr ? weight_now : PLAIN_WEIGHT)};
            if (tally_seen[lbl])
                sum = sum + {1'b0, tally_count[lbl]};
            if (sum > {1'b0, VOTE_MAX})
                sum = {1'b0, VOTE_MAX};
            tally_count[lbl] = sum[15:0];
            tally_seen[lbl]  = 1'b1;
            if (sum[15:0] > lead_votes || (sum[15:0] == lead_votes && lbl < lead_label)) begin
                lead_votes = sum[15:0];
                lead_label = lbl;
            end
        end
        if (!lst)
            return 1'b0;
        if (tally_nodata)
            res = '{tally_center, 1'b1, 16'd0};
        else
            res = '{lead_label, 1'b0, lead_votes};
        // The next window starts from a cleared tally.
        tally_seen   = '{default: 1'b0};
        lead_label   = '0;
        lead_votes   = '0;
        tally_center = '0;
        tally_nodata = 1'b0;
        return 1'b1;
    endfunction

    // Offers one pixel item after a random gap and records its expected result.
    task automatic send_pixel(t_label lbl, logic ctr, logic lst, logic typed,
                              t_vote_result typed_res);
        int unsigned  gap;
        t_vote_result res;
        gap = sender_gapless ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_label <= lbl;
        pix_if.is_center   <= ctr;
        pix_if.window_last <= lst;
        do @(posedge clk); while (!pix_if.ready);
        pixel_count++;
        if (tally_pixel(lbl, ctr, lst, res)) begin
            window_count++;
            if (res.nodata)
                nodata_windows++;
            if (res.votes == VOTE_MAX)
                saturated_windows++;
            expected_results.insert(expected_results.size(), typed ? typed_res : res);
        end
    endtask

    // Stops offering pixels and waits until every expected result has arrived.
    task automatic drain_results();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the center weight once the block has gone idle.
    task automatic write_weight(t_weight w);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.center_weight <= w;
        do @(posedge clk); while (!cfg_if.ready);
        weight_now = w;
        weight_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // One random window: mostly a small label pool for real majorities and ties,
    // some nodata, and now and then no center or two centers.
    task automatic send_window(int unsigned len, bit noisy);
        t_label      pool [3];
        t_label      lbl;
        int unsigned center_a;
        int unsigned center_b;
        int unsigned pick;
        int unsigned shape;
        for (int k = 0; k < 3; k++)
            pool[k] = t_label'($urandom_range(0, 254));
        center_a = $urandom_range(0, len - 1);
        center_b = $urandom_range(0, len - 1);
        shape    = $urandom_range(0, 9);
        if (shape == 0)
            center_a = len;
        if (shape != 1)
            center_b = len;
        sender_gapless = ($urandom_range(0, 3) == 0);
        for (int unsigned p = 0; p < len; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                lbl = NODATA_LABEL;
            else if (!noisy && pick < 75)
                lbl = pool[$urandom_range(0, 2)];
            else
                lbl = t_label'($urandom_range(0, 255));
            send_pixel(lbl, (p == center_a) || (p == center_b), p == len - 1, 1'b0, '0);
        end
    endtask

    // A phase of random windows under one weight.
    task automatic run_phase(t_weight w, int items);
        int start;
        write_weight(w);
        start = pixel_count;
        while (pixel_count - start < items) begin
            send_window($urandom_range(1, 9), $urandom_range(0, 9) == 0);
            // Occasionally let the pipeline run dry mid-phase.
            if ($urandom_range(0, 11) == 0)
                drain_results();
        end
    endtask

    // Result monitor: each accepted result against the oldest expectation.
    always @(posedge clk) begin
        t_vote_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with none expected: filtered_label %0d",
                       res_if.filtered_label);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (res_if.filtered_label !== want.label) begin
                    $error("filtered_label: expected %0d, actual %0d",
                           want.label, res_if.filtered_label);
                    mismatches++;
                end
                if (res_if.nodata_hit !== want.nodata) begin
                    $error("nodata_hit: expected %0d, actual %0d",
                           want.nodata, res_if.nodata_hit);
                    mismatches++;
                end
                if (res_if.winning_votes !== want.votes) begin
                    $error("winning_votes: expected %0d, actual %0d",
                           want.votes, res_if.winning_votes);
                    mismatches++;
                end
            end
        end
    end

    // Result receiver: random stalls, gapless stretches, and one long hold-off on request.
    initial begin
        int unsigned gap;
        res_if.ready     = 1'b0;
        receiver_gapless = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                if ($urandom_range(0, 15) == 0)
                    receiver_gapless = !receiver_gapless;
                gap = receiver_gapless ? 0 : $urandom_range(0, 4);
                if (gap != 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid && res_if.ready));
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed table, saturation, random phases, receiver hold-off, drain.
    initial begin
        t_vote_result typed_res;
        rst_n                = 1'b0;
        pix_if.valid         = 1'b0;
        pix_if.pixel_label   = '0;
        pix_if.is_center     = 1'b0;
        pix_if.window_last   = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.center_weight = '0;
        cycle_count          = 0;
        mismatches           = 0;
        pixel_count          = 0;
        window_count         = 0;
        nodata_windows       = 0;
        saturated_windows    = 0;
        weight_writes        = 0;
        sender_gapless       = 1'b0;
        hold_request         = 1'b0;
        weight_now           = CENTER_WEIGHT_RESET;
        tally_seen           = '{default: 1'b0};
        lead_label           = '0;
        lead_votes           = '0;
        tally_center         = '0;
        tally_nodata         = 1'b0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed windows, the first ones under the reset weight.
        for (int r = 0; r < DIRECTED_N; r++) begin
            if (DIRECTED[r].set_weight)
                write_weight(DIRECTED[r].weight);
            typed_res = '{DIRECTED[r].want_label, DIRECTED[r].want_nodata,
                          DIRECTED[r].want_votes};
            send_pixel(DIRECTED[r].label, DIRECTED[r].center, DIRECTED[r].last,
                       DIRECTED[r].typed, typed_res);
        end

        // Full-weight centers on one label drive its count into saturation.
        sender_gapless = 1'b1;
        for (int p = 0; p < SAT_WINDOW - 1; p++)
            send_pixel(8'd17, 1'b1, 1'b0, 1'b0, '0);
        typed_res = '{8'd17, 1'b0, VOTE_MAX};
        send_pixel(8'd17, 1'b1, 1'b1, 1'b1, typed_res);

        run_phase(8'd1, 30);
        run_phase(8'd0, 30);

        // Receiver holds off while short windows keep coming, so the block backs up.
        write_weight(8'd3);
        hold_request = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_window($urandom_range(1, 2), 1'b0);
            sender_gapless = 1'b1;
        end

        run_phase(8'd255, 30);
        run_phase(t_weight'($urandom_range(2, 254)), 30);
        run_phase(t_weight'($urandom_range(2, 254)), 30);
        run_phase(t_weight'($urandom_range(0, 255)), 30);
        run_phase(8'd1, 30);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pixel items in %0d windows: %0d with nodata, %0d saturated.",
                 pixel_count, window_count, nodata_windows, saturated_windows);
        $display("Used %0d center weight writes, including 0, 1 and 255, and one long stall.",
                 weight_writes);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wmwv_pkg.sv
sv/wmwv_if.sv
sv/weighted_majority_window_vote.sv
sv/wmwv_checker.sv
tb/testbench.sv
